### design/gb18030_sequence_segmenter_indexer_top_macros.svh
// ----------------------------------------------------------------------------
// GB18030 segmenter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle during reset.
// ----------------------------------------------------------------------------
`ifndef GB18030_SEQUENCE_SEGMENTER_INDEXER_TOP_MACROS_SVH
`define GB18030_SEQUENCE_SEGMENTER_INDEXER_TOP_MACROS_SVH

// Same-cycle implication.
`define GBSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gbsi_pkg.sv
// ----------------------------------------------------------------------------
// GB18030 segmenter package
// Types and fixed constants shared by the segmenter modules.
// ----------------------------------------------------------------------------
package gbsi_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_SECOND = 2'd2,
    PH_THIRD  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_TWO    = 2'd1,
    KIND_BMP    = 2'd2,
    KIND_SUPP   = 2'd3
  } kind_e;

  localparam logic [7:0]  LeadLo     = 8'h81;
  localparam logic [7:0]  LeadHi     = 8'hFE;
  localparam logic [7:0]  DigLo      = 8'h30;
  localparam logic [7:0]  DigHi      = 8'h39;
  localparam logic [7:0]  TrailBase  = 8'h40;
  localparam logic [14:0] TwoByteRow = 15'd190;
  localparam logic [14:0] MulSecond  = 15'd1260;
  localparam logic [20:0] MulFirst   = 21'd12600;
  localparam logic [20:0] SuppBase   = 21'h10000;
  localparam logic [6:0]  SuppLead   = 7'h10;
  localparam logic [10:0] MulThird   = 11'd10;

  // Decoder verdict for the byte in the input register.
  typedef struct packed {
    logic        emit;
    phase_e      phase_nxt;
    kind_e       kind;
    logic [20:0] value;
  } dec_t;

endpackage

### design/gbsi_if.sv
// ----------------------------------------------------------------------------
// GB18030 segmenter channels
// Valid/ready channels for the byte input and the sequence result.
// ----------------------------------------------------------------------------
interface gbsi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface gbsi_seq_if;
  logic        valid;
  logic        ready;
  logic [1:0]  seq_kind;
  logic [20:0] seq_value;

  modport source (output valid, output seq_kind, output seq_value, input ready);
  modport sink   (input valid, input seq_kind, input seq_value, output ready);
endinterface

### design/gb18030_sequence_segmenter_indexer_top.sv
// Path: a completing byte passes through the input register and then the result register.
// Throughput: one byte per cycle, set by the single decode step between the
// input register and the result register; a stalled result halts only bytes
// that would complete a sequence.
// Reset: asynchronous and active low; clears the phase, saved bytes and valids.
// ----------------------------------------------------------------------------
// GB18030 sequence segmenter and indexer
// Splits a GB18030 byte stream into sequences and emits a kind and a value.
// ----------------------------------------------------------------------------
`include "gb18030_sequence_segmenter_indexer_top_macros.svh"

module gb18030_sequence_segmenter_indexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  gbsi_byte_if.sink   in_i,
  gbsi_seq_if.source  out_o
);

  logic             s1_vld;
  logic [7:0]       s1_byte;
  logic             adv;
  logic             out_free;
  gbsi_pkg::dec_t   dec;

  gbsi_pkg::phase_e phase_q;
  logic [7:0]       first_q;
  logic [7:0]       second_q;
  logic [7:0]       third_q;
  logic             out_vld_q;
  gbsi_pkg::kind_e  out_kind_q;
  logic [20:0]      out_value_q;

  gbsi_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .vld_o  (s1_vld),
    .byte_o (s1_byte)
  );

  gbsi_decode u_decode (
    .phase_i  (phase_q),
    .first_i  (first_q),
    .second_i (second_q),
    .third_i  (third_q),
    .byte_i   (s1_byte),
    .dec_o    (dec)
  );

  assign out_free = !out_vld_q || out_o.ready;
  // Bytes that only extend a sequence never wait on the result register.
  assign adv      = s1_vld && (!dec.emit || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= gbsi_pkg::PH_IDLE;
      first_q   <= 8'd0;
      second_q  <= 8'd0;
      third_q   <= 8'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        phase_q <= dec.phase_nxt;
        if (!dec.emit) begin
          unique case (phase_q)
            gbsi_pkg::PH_IDLE:   first_q  <= s1_byte;
            gbsi_pkg::PH_LEAD:   second_q <= s1_byte;
            gbsi_pkg::PH_SECOND: third_q  <= s1_byte;
            default:             third_q  <= third_q;
          endcase
        end
      end
      if (adv && dec.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && dec.emit) begin
      out_kind_q  <= dec.kind;
      out_value_q <= dec.value;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.seq_kind  = out_kind_q;
  assign out_o.seq_value = out_value_q;

  `GBSI_ASSERT_NOW(a_emit_closes, adv && dec.emit, dec.phase_nxt == gbsi_pkg::PH_IDLE, "result emitted with a sequence still open")
  `GBSI_ASSERT_NEXT(a_third_then_close, adv && phase_q == gbsi_pkg::PH_THIRD, phase_q == gbsi_pkg::PH_IDLE && out_vld_q, "fourth byte did not close the sequence")
  `GBSI_ASSERT_NEXT(a_single_range, adv && dec.emit && dec.kind == gbsi_pkg::KIND_SINGLE, out_value_q < 21'd128, "single-byte value exceeds seven bits")
  `GBSI_ASSERT_NEXT(a_supp_range, adv && dec.emit && dec.kind == gbsi_pkg::KIND_SUPP, out_value_q >= gbsi_pkg::SuppBase, "supplementary value below the base")

endmodule

### design/gbsi_in_stage.sv
// ----------------------------------------------------------------------------
// GB18030 segmenter input register
// Captures one byte per transaction and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module gbsi_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbsi_byte_if.sink  in_i,
  input  logic       adv_i,
  output logic       vld_o,
  output logic [7:0] byte_o
);

  logic       vld_q;
  logic [7:0] byte_q;

  // A new byte may enter whenever the held one leaves in the same cycle.
  assign in_i.ready = !vld_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

### design/gbsi_decode.sv
// ----------------------------------------------------------------------------
// GB18030 segmenter decoder
// Classifies the current byte against the open sequence and forms the result.
// ----------------------------------------------------------------------------
module gbsi_decode (
  input  gbsi_pkg::phase_e phase_i,
  input  logic [7:0]       first_i,
  input  logic [7:0]       second_i,
  input  logic [7:0]       third_i,
  input  logic [7:0]       byte_i,
  output gbsi_pkg::dec_t   dec_o
);

  logic        is_lead;
  logic        is_digit;
  logic [6:0]  row;
  logic [7:0]  col;
  logic [14:0] idx2;
  logic [6:0]  f7;
  logic [6:0]  t7;
  logic [10:0] lo11;
  logic [14:0] lo15;
  logic        supp;
  logic [20:0] hi;
  logic [20:0] val4;

  assign is_lead  = (byte_i >= gbsi_pkg::LeadLo) && (byte_i <= gbsi_pkg::LeadHi);
  assign is_digit = (byte_i >= gbsi_pkg::DigLo) && (byte_i <= gbsi_pkg::DigHi);

  // Two-byte index: the trail byte skips 0x7F, so bytes above it move down one.
  assign row  = first_i[6:0] - 7'd1;
  assign col  = byte_i - {7'd0, byte_i[7]} - gbsi_pkg::TrailBase;
  assign idx2 = 15'(row) * gbsi_pkg::TwoByteRow + 15'(col);

  // Four-byte value, built from the mixed-radix digits of the sequence.
  assign f7   = first_i[6:0];
  assign t7   = third_i[6:0] - 7'd1;
  assign lo11 = 11'(t7) * gbsi_pkg::MulThird + 11'(byte_i[3:0]);
  assign lo15 = 15'(second_i[3:0]) * gbsi_pkg::MulSecond + 15'(lo11);
  assign supp = (f7 >= gbsi_pkg::SuppLead);
  assign hi   = supp ? (21'(f7 - gbsi_pkg::SuppLead) * gbsi_pkg::MulFirst + gbsi_pkg::SuppBase)
                     : (21'(f7 - 7'd1) * gbsi_pkg::MulFirst);
  assign val4 = hi + 21'(lo15);

  always_comb begin
    dec_o.emit      = 1'b0;
    dec_o.phase_nxt = gbsi_pkg::PH_IDLE;
    dec_o.kind      = gbsi_pkg::KIND_SINGLE;
    dec_o.value     = 21'(byte_i[6:0]);
    unique case (phase_i)
      gbsi_pkg::PH_IDLE: begin
        if (is_lead) begin
          dec_o.phase_nxt = gbsi_pkg::PH_LEAD;
        end else begin
          dec_o.emit = 1'b1;
        end
      end
      gbsi_pkg::PH_LEAD: begin
        if (is_digit) begin
          dec_o.phase_nxt = gbsi_pkg::PH_SECOND;
        end else begin
          dec_o.emit  = 1'b1;
          dec_o.kind  = gbsi_pkg::KIND_TWO;
          dec_o.value = 21'(idx2);
        end
      end
      gbsi_pkg::PH_SECOND: begin
        dec_o.phase_nxt = gbsi_pkg::PH_THIRD;
      end
      gbsi_pkg::PH_THIRD: begin
        dec_o.emit  = 1'b1;
        dec_o.kind  = supp ? gbsi_pkg::KIND_SUPP : gbsi_pkg::KIND_BMP;
        dec_o.value = val4;
      end
      default: begin
        dec_o.phase_nxt = gbsi_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

### tb/gb18030_sequence_segmenter_indexer_top_tb.sv
// ----------------------------------------------------------------------------
// GB18030 segmenter testbench
// Feeds random and hand-picked byte streams through the segmenter and checks
// every emitted kind and value against a sequence decoder kept in step here.
// ----------------------------------------------------------------------------
module gb18030_sequence_segmenter_indexer_top_tb;

  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned RandBytes  = 1200;

  typedef struct packed {
    gbsi_pkg::kind_e kind;
    logic [20:0]     value;
  } seq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gbsi_byte_if byte_ch ();
  gbsi_seq_if  seq_ch ();

  gb18030_sequence_segmenter_indexer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch.sink),
    .out_o  (seq_ch.source)
  );

  logic [7:0]  byte_q[$];
  seq_result_t seq_expect_q[$];

  // Decoder state mirrored from the block.
  gbsi_pkg::phase_e dec_phase = gbsi_pkg::PH_IDLE;
  logic [7:0]       lead_b    = 8'h00;
  logic [7:0]       second_b  = 8'h00;
  logic [7:0]       third_b   = 8'h00;

  int unsigned err_cnt      = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;

  int unsigned tx_gap;
  int unsigned tx_calm;
  int unsigned rx_stall;
  int unsigned rx_calm;
  int unsigned hold_left;
  bit          hold_done;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advances the decoder by one accepted byte and queues any completed sequence.
  function automatic void segment_byte(input logic [7:0] b);
    seq_result_t res;
    int unsigned lead7, trail, lo11, lo15, f7;
    bit          emit;
    emit = 1'b0;
    case (dec_phase)
      gbsi_pkg::PH_IDLE: begin
        if (b >= gbsi_pkg::LeadLo && b <= gbsi_pkg::LeadHi) begin
          lead_b    = b;
          dec_phase = gbsi_pkg::PH_LEAD;
        end else begin
          emit      = 1'b1;
          res.kind  = gbsi_pkg::KIND_SINGLE;
          res.value = 21'(b[6:0]);
        end
      end
      gbsi_pkg::PH_LEAD: begin
        if (b >= gbsi_pkg::DigLo && b <= gbsi_pkg::DigHi) begin
          second_b  = b;
          dec_phase = gbsi_pkg::PH_SECOND;
        end else begin
          lead7     = (32'(lead_b[6:0]) - 32'd1) & 32'h7F;
          trail     = (32'(b) - 32'(b[7]) - 32'h40) & 32'hFF;
          emit      = 1'b1;
          res.kind  = gbsi_pkg::KIND_TWO;
          res.value = 21'((lead7 * 190 + trail) & 32'h7FFF);
          dec_phase = gbsi_pkg::PH_IDLE;
        end
      end
      gbsi_pkg::PH_SECOND: begin
        third_b   = b;
        dec_phase = gbsi_pkg::PH_THIRD;
      end
      default: begin
        lo11 = ((((32'(third_b[6:0]) - 32'd1) & 32'h7F) * 10) + 32'(b[3:0])) & 32'h7FF;
        lo15 = (32'(second_b[3:0]) * 1260 + lo11) & 32'h7FFF;
        f7   = 32'(lead_b[6:0]);
        emit = 1'b1;
        if (f7 >= 16) begin
          res.kind  = gbsi_pkg::KIND_SUPP;
          res.value = 21'(((f7 - 16) * 12600 + 32'h10000 + lo15) & 32'h1FFFFF);
        end else begin
          res.kind  = gbsi_pkg::KIND_BMP;
          res.value = 21'((((f7 - 32'd1) & 32'h7F) * 12600 + lo15) & 32'h1FFFFF);
        end
        dec_phase = gbsi_pkg::PH_IDLE;
      end
    endcase
    if (emit) seq_expect_q.push_back(res);
  endfunction

  // Byte driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.in_byte <= 8'h00;
      tx_gap          <= 0;
      tx_calm         <= 0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (tx_gap != 0) begin
        byte_ch.valid <= 1'b0;
        tx_gap        <= tx_gap - 1;
      end else if (byte_q.size() != 0) begin
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= byte_q.pop_front();
        if (tx_calm != 0) begin
          tx_gap  <= 0;
          tx_calm <= tx_calm - 1;
        end else if ($urandom_range(0, 99) < 2) begin
          tx_gap  <= 0;
          tx_calm <= $urandom_range(40, 120);
        end else begin
          tx_gap <= pick_gap();
        end
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off once traffic is under way.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_ch.ready <= 1'b0;
      rx_stall     <= 0;
      rx_calm      <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      seq_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      seq_ch.ready <= 1'b0;
      hold_done    <= 1'b1;
      hold_left    <= 300;
    end else if (rx_stall != 0) begin
      seq_ch.ready <= 1'b0;
      rx_stall     <= rx_stall - 1;
    end else if (rx_calm != 0) begin
      seq_ch.ready <= 1'b1;
      rx_calm      <= rx_calm - 1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:1]:   begin seq_ch.ready <= 1'b1; rx_calm <= $urandom_range(50, 150); end
        [2:69]:  seq_ch.ready <= 1'b1;
        [70:94]: begin seq_ch.ready <= 1'b0; rx_stall <= $urandom_range(0, 2); end
        default: begin seq_ch.ready <= 1'b0; rx_stall <= $urandom_range(8, 30); end
      endcase
    end
  end

  // Prediction on accepted bytes, then comparison of accepted results.
  always @(posedge clk_i) begin
    seq_result_t exp_res;
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) segment_byte(byte_ch.in_byte);
      if (seq_ch.valid && seq_ch.ready) begin
        results_seen <= results_seen + 1;
        if (seq_expect_q.size() == 0) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= 10)
            $display("Unexpected result: kind %0d value 0x%06h",
                     seq_ch.seq_kind, seq_ch.seq_value);
        end else begin
          exp_res = seq_expect_q.pop_front();
          if (seq_ch.seq_kind !== exp_res.kind || seq_ch.seq_value !== exp_res.value) begin
            err_cnt = err_cnt + 1;
            if (err_cnt <= 10)
              $display("Mismatch: expected kind %0d value 0x%06h, got kind %0d value 0x%06h",
                       exp_res.kind, exp_res.value, seq_ch.seq_kind, seq_ch.seq_value);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (seq_ch.valid && seq_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  lead, b;
    int unsigned pick;

    // Non-lead singles at the edges, including 0x80 and 0xFF.
    byte_q = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    // Two-byte: smallest and largest well-formed, then trail bytes out of range.
    byte_q.push_back(8'h81); byte_q.push_back(8'h40);
    byte_q.push_back(8'hFE); byte_q.push_back(8'hFE);
    byte_q.push_back(8'h81); byte_q.push_back(8'hFF);
    byte_q.push_back(8'h81); byte_q.push_back(8'h00);
    // Four-byte: lowest BMP, highest supplementary, then a malformed third
    // and fourth byte on the first supplementary lead.
    byte_q.push_back(8'h81); byte_q.push_back(8'h30);
    byte_q.push_back(8'h81); byte_q.push_back(8'h30);
    byte_q.push_back(8'hFE); byte_q.push_back(8'h39);
    byte_q.push_back(8'hFE); byte_q.push_back(8'h39);
    byte_q.push_back(8'h90); byte_q.push_back(8'h30);
    byte_q.push_back(8'h00); byte_q.push_back(8'hFF);

    while (byte_q.size() < RandBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        do b = 8'($urandom_range(0, 255)); while (b >= gbsi_pkg::LeadLo && b <= gbsi_pkg::LeadHi);
        byte_q.push_back(b);
      end else if (pick < 55) begin
        byte_q.push_back(8'($urandom_range(8'h81, 8'hFE)));
        if ($urandom_range(0, 99) < 80) begin
          b = 8'($urandom_range(8'h40, 8'hFE));
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b >= gbsi_pkg::DigLo && b <= gbsi_pkg::DigHi);
        end
        byte_q.push_back(b);
      end else if (pick < 87) begin
        // Keep BMP leads about as common as supplementary ones.
        if ($urandom_range(0, 1) == 0) lead = 8'($urandom_range(8'h81, 8'h8F));
        else lead = 8'($urandom_range(8'h90, 8'hFE));
        byte_q.push_back(lead);
        byte_q.push_back(8'($urandom_range(8'h30, 8'h39)));
        if ($urandom_range(0, 99) < 80) byte_q.push_back(8'($urandom_range(8'h81, 8'hFE)));
        else byte_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 80) byte_q.push_back(8'($urandom_range(8'h30, 8'h39)));
        else byte_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        byte_q.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampled on the falling edge so that the clocked blocks have settled.
    do @(negedge clk_i); while (byte_q.size() != 0 || byte_ch.valid);
    do @(negedge clk_i); while (seq_expect_q.size() != 0);
    repeat (TailCycles) @(negedge clk_i);

    if (err_cnt == 0 && seq_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/gbsi_pkg.sv
design/gbsi_if.sv
design/gbsi_in_stage.sv
design/gbsi_decode.sv
design/gb18030_sequence_segmenter_indexer_top.sv
tb/gb18030_sequence_segmenter_indexer_top_tb.sv
